### hdl/btc3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary threshold closing package
// Shared widths, reset values, register indexes and payload constants for the
// 3x3 threshold-and-closing block and its stream interfaces.
// ----------------------------------------------------------------------------
package btc3_pkg;

  // Payload field widths.
  localparam int PIX_W = 8;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int THR_FIELD_W    = 8;
  localparam int WIDTH_FIELD_W  = 11;
  localparam int HEIGHT_FIELD_W = 13;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd2;

  // Register reset values.
  localparam logic [THR_FIELD_W-1:0] THRESHOLD_RESET = 8'd127;
  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;

  // Smallest frame dimension the window logic supports.
  localparam int MIN_DIM = 3;

  // Default frame size limits.
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;

  // Binary pixel levels on the output.
  localparam logic [PIX_W-1:0] PIX_FG = 8'd255;
  localparam logic [PIX_W-1:0] PIX_BG = 8'd0;

endpackage

### hdl/btc3_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel input stream interface
// Valid/ready channel carrying one gray pixel and its flush marker.
// ----------------------------------------------------------------------------
interface btc3_in_if;
  logic                          valid;
  logic                          ready;
  logic [btc3_pkg::PIX_W-1:0]    pixel_in;
  logic                          flush;

  modport source (output valid, output pixel_in, output flush, input ready);
  modport sink   (input valid, input pixel_in, input flush, output ready);
endinterface

### hdl/btc3_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel output stream interface
// Valid/ready channel carrying one closed binary pixel and its frame marker.
// ----------------------------------------------------------------------------
interface btc3_out_if;
  logic                          valid;
  logic                          ready;
  logic [btc3_pkg::PIX_W-1:0]    pixel_out;
  logic                          frame_last;

  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

### hdl/binary_threshold_closing_3x3.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary threshold closing, 3x3
// Thresholds a raster pixel stream and applies a 3x3 binary closing
// (dilation followed by erosion) using a two-row line store per stage.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on in_px in raster order, one transaction per pixel. After
//   the last pixel of a frame the source sends flush transactions (two rows
//   plus two pixels) to drain the window; the result for pixel (r,c) leaves
//   when raster position (r+2)*width+c+2 is accepted.
//   out_px carries one closed pixel (0 or 255) per result; frame_last marks
//   the last pixel of the frame, after which the raster restarts.
//   The block accepts one transaction per clock unless the output stalls;
//   the line stores, each with one read and one write port used once per
//   pixel, set this rate. A result passes the stage 1, stage 2 and output
//   registers. When the receiver stalls, the output register holds and the
//   whole three-stage pipeline freezes, so in_px.ready drops the same cycle.
//   cfg_we writes threshold, width or height; writing width or height
//   restarts the raster position. Configure only while the block is idle.
//   Reset (rst_n low, synchronous) restores the default registers and the
//   raster start; line store contents are never read before rewritten.
// ----------------------------------------------------------------------------
module binary_threshold_closing_3x3 #(
  parameter int MAX_WIDTH  = btc3_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = btc3_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  btc3_in_if.sink                             in_px,
  btc3_out_if.source                          out_px,
  input  logic                                cfg_we,
  input  logic [btc3_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [btc3_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  // Widths derived from the frame limits.
  localparam int CW  = $clog2(MAX_WIDTH);        // column index
  localparam int WW  = $clog2(MAX_WIDTH + 1);    // width and column arithmetic
  localparam int HW  = $clog2(MAX_HEIGHT + 1);   // height
  localparam int RW  = $clog2(MAX_HEIGHT + 3);   // row counter, up to height+2
  localparam int RXW = $clog2(MAX_HEIGHT + 4);   // row arithmetic, up to height+3

  localparam int WDef = (btc3_pkg::WIDTH_RESET < btc3_pkg::MIN_DIM) ? btc3_pkg::MIN_DIM :
                        (btc3_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH :
                        btc3_pkg::WIDTH_RESET;
  localparam int HDef = (btc3_pkg::HEIGHT_RESET < btc3_pkg::MIN_DIM) ? btc3_pkg::MIN_DIM :
                        (btc3_pkg::HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT :
                        btc3_pkg::HEIGHT_RESET;

  // Stage 1 carries the threshold bit, the dilation window control and the erosion control.
  typedef struct packed {
    logic          tbit;
    logic [CW-1:0] tcol;
    logic [CW-1:0] dcol;
    logic          mask_top;
    logic          mask_bot;
    logic          mask_left;
    logic          mask_right;
    logic          emit;
    logic          interior;
    logic          last;
  } s1_t;

  // Stage 2 carries the dilated bit and the erosion control.
  typedef struct packed {
    logic          dbit;
    logic [CW-1:0] dcol;
    logic          emit;
    logic          interior;
    logic          last;
  } s2_t;

  // Configuration and raster position registers.
  logic [btc3_pkg::THR_FIELD_W-1:0] thr_r;
  logic [WW-1:0]                    w_r, w_nxt;
  logic [HW-1:0]                    h_r, h_nxt;
  logic [CW-1:0]                    col_r, col_nxt;
  logic [RW-1:0]                    row_r, row_nxt;

  // Pipeline registers.
  logic        s1_valid_r, s2_valid_r, out_valid_r;
  s1_t         s1_r, s1_nxt;
  s2_t         s2_r, s2_nxt;
  logic [2:0]  tw1_r, tw2_r, dw1_r, dw2_r;
  logic [1:0]  t_rd_r, d_rd_r;
  logic [btc3_pkg::PIX_W-1:0] out_pix_r;
  logic        out_last_r;

  // Line stores: two rows of history per column.
  logic [1:0]  tmem [MAX_WIDTH];
  logic [1:0]  dmem [MAX_WIDTH];

  // Stage 0 signals.
  logic            adv, accept;
  logic            wrap;
  logic [CW-1:0]   col0;
  logic [RW-1:0]   row0;
  logic [WW-1:0]   col0_x, ecol_x;
  logic [RXW-1:0]  row0_x, h_x, erow_x;
  logic            col_ge1, col_ge2;

  // Stage 1 and 2 signals.
  logic [2:0]  tcol_v, rowmask, dil_or;
  logic        dil_bit;
  logic [2:0]  dcol_v;
  logic        ero_bit;

  // Clamp configuration writes to the supported frame size.
  logic [31:0] wv, hv;
  always_comb begin
    wv = 32'(cfg_wdata[btc3_pkg::WIDTH_FIELD_W-1:0]);
    hv = 32'(cfg_wdata[btc3_pkg::HEIGHT_FIELD_W-1:0]);
    if (wv < 32'(btc3_pkg::MIN_DIM)) begin
      w_nxt = WW'(btc3_pkg::MIN_DIM);
    end else if (wv > 32'(MAX_WIDTH)) begin
      w_nxt = WW'(MAX_WIDTH);
    end else begin
      w_nxt = WW'(wv);
    end
    if (hv < 32'(btc3_pkg::MIN_DIM)) begin
      h_nxt = HW'(btc3_pkg::MIN_DIM);
    end else if (hv > 32'(MAX_HEIGHT)) begin
      h_nxt = HW'(MAX_HEIGHT);
    end else begin
      h_nxt = HW'(hv);
    end
  end

  // The whole pipeline moves when the output register is free or drained.
  assign adv          = !out_valid_r || out_px.ready;
  assign accept       = in_px.valid && adv;
  assign in_px.ready  = adv;

  // Stage 0: raster position, threshold and window control for this pixel.
  always_comb begin
    h_x     = RXW'(h_r);
    wrap    = (WW'(col_r) >= w_r) || (RXW'(row_r) >= h_x + RXW'(3));
    col0    = wrap ? '0 : col_r;
    row0    = wrap ? '0 : row_r;
    col0_x  = WW'(col0);
    row0_x  = RXW'(row0);
    col_ge1 = (col0 != '0);
    col_ge2 = (col0_x >= WW'(2));

    s1_nxt.tbit = !in_px.flush && (in_px.pixel_in > thr_r) && (row0_x < h_x);
    s1_nxt.tcol = col0;
    // The dilated pixel sits one row and one column behind.
    s1_nxt.dcol       = col_ge1 ? (col0 - CW'(1)) : CW'(w_r - WW'(1));
    s1_nxt.mask_top   = col_ge1 ? (row0_x < RXW'(2)) : (row0_x < RXW'(3));
    s1_nxt.mask_bot   = col_ge1 ? (row0_x >= h_x) : (row0_x >= h_x + RXW'(1));
    s1_nxt.mask_left  = (col0 == CW'(1));
    s1_nxt.mask_right = !col_ge1;

    // The eroded pixel sits two rows and two columns behind.
    if (col_ge2) begin
      erow_x      = row0_x - RXW'(2);
      ecol_x      = col0_x - WW'(2);
      s1_nxt.emit = (row0_x >= RXW'(2)) && (row0_x < h_x + RXW'(2));
    end else begin
      erow_x      = row0_x - RXW'(3);
      ecol_x      = col0_x + w_r - WW'(2);
      s1_nxt.emit = (row0_x >= RXW'(3)) && (row0_x < h_x + RXW'(3));
    end
    s1_nxt.interior = (erow_x >= RXW'(1)) && (erow_x <= h_x - RXW'(2)) &&
                      (ecol_x >= WW'(1)) && (ecol_x <= w_r - WW'(2));
    s1_nxt.last     = (erow_x == h_x - RXW'(1)) && (ecol_x == w_r - WW'(1));

    // Advance the raster, restarting after the last pixel of the frame.
    priority if (s1_nxt.emit && s1_nxt.last) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (col0_x + WW'(1) >= w_r) begin
      col_nxt = '0;
      row_nxt = RW'(row0_x + RXW'(1));
    end else begin
      col_nxt = col0 + CW'(1);
      row_nxt = row0;
    end
  end

  // Configuration registers and raster position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= btc3_pkg::THRESHOLD_RESET;
      w_r   <= WW'(WDef);
      h_r   <= HW'(HDef);
      col_r <= '0;
      row_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          btc3_pkg::REG_THRESHOLD: thr_r <= cfg_wdata[btc3_pkg::THR_FIELD_W-1:0];
          btc3_pkg::REG_WIDTH: begin
            w_r   <= w_nxt;
            col_r <= '0;
            row_r <= '0;
          end
          btc3_pkg::REG_HEIGHT: begin
            h_r   <= h_nxt;
            col_r <= '0;
            row_r <= '0;
          end
          default: ;
        endcase
      end else if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  // Threshold line store: read at stage 0, write back shifted at stage 1.
  always_ff @(posedge clk) begin
    if (accept) begin
      t_rd_r <= tmem[col0];
    end
    if (adv && s1_valid_r) begin
      tmem[s1_r.tcol] <= {t_rd_r[0], s1_r.tbit};
    end
  end

  // Stage 1: 3x3 dilation over the column vectors, outside rows and columns
  // counting as background.
  always_comb begin
    tcol_v  = {t_rd_r[1], t_rd_r[0], s1_r.tbit};
    rowmask = {!s1_r.mask_top, 1'b1, !s1_r.mask_bot};
    dil_or  = (tcol_v & {3{!s1_r.mask_right}}) | tw1_r | (tw2_r & {3{!s1_r.mask_left}});
    dil_bit = |(dil_or & rowmask);

    s2_nxt.dbit     = dil_bit;
    s2_nxt.dcol     = s1_r.dcol;
    s2_nxt.emit     = s1_r.emit;
    s2_nxt.interior = s1_r.interior;
    s2_nxt.last     = s1_r.last;
  end

  // Dilated line store: read at stage 1, write back shifted at stage 2.
  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      d_rd_r <= dmem[s1_r.dcol];
    end
    if (adv && s2_valid_r) begin
      dmem[s2_r.dcol] <= {d_rd_r[0], s2_r.dbit};
    end
  end

  // Stage 2: 3x3 erosion; border pixels give background.
  always_comb begin
    dcol_v  = {d_rd_r[1], d_rd_r[0], s2_r.dbit};
    ero_bit = s2_r.interior && (&dcol_v) && (&dw1_r) && (&dw2_r);
  end

  // Pipeline valid bits and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= accept;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r && s2_r.emit;
    end
  end

  // Pipeline payload and the column windows, shifted only by real pixels.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r       <= s1_nxt;
      s2_r       <= s2_nxt;
      out_pix_r  <= ero_bit ? btc3_pkg::PIX_FG : btc3_pkg::PIX_BG;
      out_last_r <= s2_r.last;
      if (s1_valid_r) begin
        tw2_r <= tw1_r;
        tw1_r <= tcol_v;
      end
      if (s2_valid_r) begin
        dw2_r <= dw1_r;
        dw1_r <= dcol_v;
      end
    end
  end

  assign out_px.valid      = out_valid_r;
  assign out_px.pixel_out  = out_pix_r;
  assign out_px.frame_last = out_last_r;

endmodule

### bench/binary_threshold_closing_3x3_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary threshold closing result checker
// Watches the pixel, result and register channels of the 3x3 closing block,
// keeps its own model of the raster state and of the thresholded and dilated
// rows, and compares every result transaction with the oldest predicted pixel.
// ----------------------------------------------------------------------------
module binary_threshold_closing_3x3_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  btc3_in_if                              in_mon,
  btc3_out_if                             out_mon,
  input  logic                            cfg_we,
  input  logic [btc3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [btc3_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            run_done,
  output int                              pending_results,
  output int                              fail_count
);

  localparam int MAX_W = btc3_pkg::DEF_MAX_WIDTH;
  localparam int MAX_H = btc3_pkg::DEF_MAX_HEIGHT;

  typedef struct packed {
    logic [btc3_pkg::PIX_W-1:0] pixel;
    logic                       last;
  } closed_pixel_t;

  // Predicted results, oldest first.
  closed_pixel_t expected_pixels[$];

  // Mirrored registers.
  logic [btc3_pkg::THR_FIELD_W-1:0]    thr_reg;
  logic [btc3_pkg::WIDTH_FIELD_W-1:0]  width_reg;
  logic [btc3_pkg::HEIGHT_FIELD_W-1:0] height_reg;

  // Four rows of thresholded and dilated bits, indexed by row modulo four.
  bit fg_rows  [4][MAX_W];
  bit dil_rows [4][MAX_W];

  // Position of the next pixel in the raster, which runs past the frame end.
  int col_pos;
  int row_pos;

  int mismatches = 0;
  int results_seen = 0;
  bit leftovers_checked = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Advances the raster by one pixel: threshold the new pixel, dilate the
  // pixel one row and one column behind, erode the pixel two rows and two
  // columns behind and queue that result when it lies inside the frame.
  task automatic predict_closing(input logic [btc3_pkg::PIX_W-1:0] pix, input logic fl);
    int w, h, rr, cc, y, x, r, c, yy, xx;
    bit d, e, last;
    closed_pixel_t res;
    w = int'(width_reg);
    if (w < btc3_pkg::MIN_DIM) w = btc3_pkg::MIN_DIM;
    else if (w > MAX_W) w = MAX_W;
    h = int'(height_reg);
    if (h < btc3_pkg::MIN_DIM) h = btc3_pkg::MIN_DIM;
    else if (h > MAX_H) h = MAX_H;

    if (col_pos >= w || row_pos >= h + 3) begin
      col_pos = 0;
      row_pos = 0;
    end
    rr = row_pos;
    cc = col_pos;

    // Pixels past the frame end are ignored; flush inside the frame is background.
    if (rr < h) fg_rows[rr & 3][cc] = !fl && (pix > thr_reg);

    if (cc >= 1) begin
      y = rr - 1;
      x = cc - 1;
    end else begin
      y = rr - 2;
      x = w - 1;
    end
    if (y >= 0 && y < h) begin
      // Neighbours outside the frame count as background.
      d = 1'b0;
      for (int i = -1; i <= 1; i++) begin
        for (int j = -1; j <= 1; j++) begin
          yy = y + i;
          xx = x + j;
          if (yy >= 0 && yy < h && xx >= 0 && xx < w) d |= fg_rows[yy & 3][xx];
        end
      end
      dil_rows[y & 3][x] = d;
    end

    if (cc >= 2) begin
      r = rr - 2;
      c = cc - 2;
    end else begin
      r = rr - 3;
      c = cc + w - 2;
    end
    if (r >= 0 && r < h) begin
      last = (r == h - 1) && (c == w - 1);
      // Border pixels always come out as background.
      e = 1'b0;
      if (r > 0 && r < h - 1 && c > 0 && c < w - 1) begin
        e = 1'b1;
        for (int i = -1; i <= 1; i++) begin
          for (int j = -1; j <= 1; j++) e &= dil_rows[(r + i) & 3][c + j];
        end
      end
      res.pixel = e ? btc3_pkg::PIX_FG : btc3_pkg::PIX_BG;
      res.last  = last;
      expected_pixels.insert(expected_pixels.size(), res);
      if (last) begin
        // The next pixel starts a new frame.
        col_pos = 0;
        row_pos = 0;
        return;
      end
    end

    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
  endtask

  // Register writes, input transactions and result transactions are handled
  // in that order within one edge, so a result always meets its prediction.
  always @(posedge clk) begin : track
    closed_pixel_t want;
    if (!rst_n) begin
      thr_reg    = btc3_pkg::THRESHOLD_RESET;
      width_reg  = btc3_pkg::WIDTH_FIELD_W'(btc3_pkg::WIDTH_RESET);
      height_reg = btc3_pkg::HEIGHT_FIELD_W'(btc3_pkg::HEIGHT_RESET);
      foreach (fg_rows[i, j]) begin
        fg_rows[i][j]  = 1'b0;
        dil_rows[i][j] = 1'b0;
      end
      expected_pixels.delete();
      col_pos = 0;
      row_pos = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          btc3_pkg::REG_THRESHOLD: thr_reg = cfg_wdata[btc3_pkg::THR_FIELD_W-1:0];
          btc3_pkg::REG_WIDTH: begin
            width_reg = cfg_wdata[btc3_pkg::WIDTH_FIELD_W-1:0];
            col_pos = 0;
            row_pos = 0;
          end
          btc3_pkg::REG_HEIGHT: begin
            height_reg = cfg_wdata[btc3_pkg::HEIGHT_FIELD_W-1:0];
            col_pos = 0;
            row_pos = 0;
          end
          default: ;
        endcase
      end

      if (in_mon.valid && in_mon.ready) predict_closing(in_mon.pixel_in, in_mon.flush);

      if (out_mon.valid && out_mon.ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected (pixel_out %0d)",
                                    results_seen, out_mon.pixel_out));
        end else begin
          want = expected_pixels.pop_front();
          if (out_mon.pixel_out !== want.pixel)
            report_mismatch($sformatf("result %0d: pixel_out %0d, expected %0d",
                                      results_seen, out_mon.pixel_out, want.pixel));
          if (out_mon.frame_last !== want.last)
            report_mismatch($sformatf("result %0d: frame_last %0b, expected %0b",
                                      results_seen, out_mon.frame_last, want.last));
        end
        results_seen++;
      end

      if (run_done && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (expected_pixels.size() != 0)
          report_mismatch($sformatf("%0d expected results never arrived",
                                    expected_pixels.size()));
      end
    end
    pending_results <= expected_pixels.size();
    fail_count      <= mismatches;
  end

endmodule

### bench/binary_threshold_closing_3x3_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary threshold closing testbench
// Streams frames of gray pixels through the 3x3 threshold-and-closing block
// under several register settings, with random gaps and stalls on both
// channels, and takes the verdict from the checker instantiated beside it.
// ----------------------------------------------------------------------------
module binary_threshold_closing_3x3_tb;

  // Index with no register behind it; writes to it must change nothing.
  localparam logic [btc3_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS     = 620;
  localparam int LONG_HOLD_CYCLES = 100;
  // Results leave the block through its pipeline registers; allow a margin.
  localparam int SETTLE_CYCLES    = 4;
  // Slowest correct run is roughly 2.5k pixels.
  localparam int TIMEOUT_NS       = 3_000_000;

  logic clk = 1'b0;
  logic rst_n;
  logic                            cfg_we;
  logic [btc3_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [btc3_pkg::CFG_DATA_W-1:0] cfg_wdata;

  btc3_in_if  in_ch ();
  btc3_out_if out_ch ();

  int pending_results;
  int fail_count;

  // Flags from the pixel sender to the result receiver.
  bit long_hold_req = 1'b0;
  bit quiet_tail    = 1'b0;
  bit run_done      = 1'b0;

  // Sender-side view of the current frame geometry.
  bit sender_gaps = 1'b1;
  int cur_thr;
  int cur_w;
  int cur_h;
  int items_sent = 0;

  always #5 clk = ~clk;

  binary_threshold_closing_3x3 DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_px     (in_ch),
    .out_px    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  binary_threshold_closing_3x3_checker closing_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .run_done        (run_done),
    .pending_results (pending_results),
    .fail_count      (fail_count)
  );

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

  // Result receiver: random stall bursts in some stretches, none in others,
  // one long hold-off on request and no stalls once the tail starts.
  initial begin : receiver
    int span;
    bit bursty;
    bit hold_done;
    span = 0;
    bursty = 1'b1;
    hold_done = 1'b0;
    forever begin
      if (long_hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else if (!quiet_tail && bursty && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
        span++;
        if (span == 200) begin
          span = 0;
          bursty = ($urandom_range(0, 1) == 1);
        end
      end
    end
  end

  function automatic int clamp_dim(input int raw, input int hi);
    return (raw < btc3_pkg::MIN_DIM) ? btc3_pkg::MIN_DIM : ((raw > hi) ? hi : raw);
  endfunction

  // Gray level that lands above the threshold with the given percentage,
  // with an occasional fully random value.
  function automatic logic [btc3_pkg::PIX_W-1:0] gray_pixel(input int fg_pct);
    if ($urandom_range(0, 9) == 0) return btc3_pkg::PIX_W'($urandom);
    if ($urandom_range(1, 100) <= fg_pct && cur_thr < 255)
      return btc3_pkg::PIX_W'($urandom_range(cur_thr + 1, 255));
    return btc3_pkg::PIX_W'($urandom_range(0, cur_thr));
  endfunction

  // Offers one pixel and returns at the edge where the transaction completes.
  task automatic send_pixel(input logic [btc3_pkg::PIX_W-1:0] pix, input logic fl);
    if (sender_gaps && !quiet_tail && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.pixel_in <= pix;
    in_ch.flush    <= fl;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    items_sent++;
  endtask

  // Stops offering pixels until every predicted result has been taken and
  // the pipeline has had time to retire pixels that produce no result.
  task automatic wait_drained();
    int calm;
    calm = 0;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    while (calm < SETTLE_CYCLES) begin
      @(posedge clk);
      if (out_ch.ready) calm++;
    end
  endtask

  task automatic write_reg(input logic [btc3_pkg::CFG_IDX_W-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= btc3_pkg::CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input int thr_data, input int width_data, input int height_data);
    write_reg(btc3_pkg::REG_THRESHOLD, thr_data);
    write_reg(btc3_pkg::REG_WIDTH, width_data);
    write_reg(btc3_pkg::REG_HEIGHT, height_data);
    cur_thr = thr_data & ((1 << btc3_pkg::THR_FIELD_W) - 1);
    cur_w = clamp_dim(width_data & ((1 << btc3_pkg::WIDTH_FIELD_W) - 1),
                      btc3_pkg::DEF_MAX_WIDTH);
    cur_h = clamp_dim(height_data & ((1 << btc3_pkg::HEIGHT_FIELD_W) - 1),
                      btc3_pkg::DEF_MAX_HEIGHT);
  endtask

  // One whole frame followed by the two rows and two pixels that drain it.
  // The tail mixes flush items with ordinary pixels, which the block ignores.
  task automatic stream_frame(input int fg_pct, input int flush_pct);
    int frame_len, total, pause_at;
    frame_len = cur_w * cur_h;
    total = frame_len + 2 * cur_w + 2;
    pause_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, total - 1) : -1;
    for (int k = 0; k < total; k++) begin
      if (k == pause_at) wait_drained();
      if (k < frame_len) begin
        if ($urandom_range(1, 100) <= flush_pct)
          send_pixel(btc3_pkg::PIX_W'($urandom), 1'b1);
        else send_pixel(gray_pixel(fg_pct), 1'b0);
      end else begin
        send_pixel(btc3_pkg::PIX_W'($urandom), $urandom_range(0, 5) != 0);
      end
    end
  endtask

  initial begin : stimulus
    int loop_start, phase, frames, kind, fg_pct, flush_pct;
    int thr_data, w_data, h_data;
    bit resync;

    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.pixel_in <= '0;
    in_ch.flush    <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= btc3_pkg::REG_THRESHOLD;
    cfg_wdata      <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Smallest frame at the reset threshold: values on both sides of it,
    // a flush inside the frame, and an ordinary pixel in the drain tail.
    write_reg(btc3_pkg::REG_WIDTH, 3);
    write_reg(btc3_pkg::REG_HEIGHT, 3);
    write_reg(REG_UNUSED, $urandom);
    cur_thr = btc3_pkg::THRESHOLD_RESET;
    cur_w = 3;
    cur_h = 3;
    send_pixel(8'h00, 1'b0); send_pixel(8'hFF, 1'b0); send_pixel(8'd127, 1'b0);
    send_pixel(8'd128, 1'b0); send_pixel(8'hFF, 1'b1); send_pixel(8'hFF, 1'b0);
    send_pixel(8'd128, 1'b0); send_pixel(8'd126, 1'b0); send_pixel(8'hFF, 1'b0);
    send_pixel(8'h00, 1'b1); send_pixel(8'h5A, 1'b1); send_pixel(8'hFF, 1'b0);
    send_pixel(8'hA5, 1'b1); send_pixel(8'h00, 1'b1); send_pixel(8'h00, 1'b1);
    send_pixel(8'h00, 1'b1); send_pixel(8'h00, 1'b1);

    // Register extremes: sizes below the minimum, masked upper data bits,
    // threshold zero and full scale. The widest rows and the tallest frame
    // are only entered for their first pixels; the next setting resyncs.
    wait_drained();
    configure(13'h1F00, 2, 1);
    stream_frame(50, 10);
    wait_drained();
    configure(13'h1FFF, 13'h1805, 0);
    stream_frame(50, 5);
    wait_drained();
    configure(128, 2047, 3);
    repeat (30) send_pixel(gray_pixel(30), 1'b0);
    wait_drained();
    configure($urandom_range(0, 255), 3, 8191);
    repeat (40) send_pixel(gray_pixel(40), 1'b0);

    // Random part: mostly whole frames, some cut short or pure noise, each
    // followed by a fresh register setting to bring the raster back in step.
    loop_start = items_sent;
    phase = 0;
    resync = 1'b0;
    while (items_sent - loop_start < RANDOM_ITEMS || phase < 2) begin
      wait_drained();
      sender_gaps = ($urandom_range(0, 3) != 0);
      fg_pct = $urandom_range(10, 90);
      flush_pct = $urandom_range(0, 1) ? 0 : 5;
      if (phase == 1) begin
        // Long output stall while pixels keep coming, so the input backs up.
        configure($urandom_range(0, 255), 12, 6);
        long_hold_req <= 1'b1;
      end else if (phase == 0 || resync || $urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 9))
          0:       thr_data = 0;
          1:       thr_data = 255;
          default: thr_data = $urandom_range(0, 255);
        endcase
        thr_data |= $urandom_range(0, 31) << btc3_pkg::THR_FIELD_W;
        case ($urandom_range(0, 19))
          0:       w_data = $urandom_range(0, 2);
          1:       w_data = $urandom_range(13, 40);
          default: w_data = $urandom_range(3, 12);
        endcase
        w_data |= $urandom_range(0, 3) << btc3_pkg::WIDTH_FIELD_W;
        h_data = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
        configure(thr_data, w_data, h_data);
      end else if ($urandom_range(0, 1) == 0) begin
        // Threshold alone; the raster carries on where it is.
        thr_data = $urandom_range(0, 255);
        write_reg(btc3_pkg::REG_THRESHOLD, thr_data);
        cur_thr = thr_data;
      end
      resync = 1'b0;
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames && !resync; f++) begin
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
          repeat ($urandom_range(1, cur_w * cur_h)) send_pixel(gray_pixel(fg_pct), 1'b0);
          resync = 1'b1;
        end else if (kind == 1) begin
          repeat ($urandom_range(5, 30))
            send_pixel(btc3_pkg::PIX_W'($urandom), $urandom_range(0, 1) == 1);
          resync = 1'b1;
        end else begin
          stream_frame(fg_pct, flush_pct);
        end
      end
      phase++;
    end

    // Tail with both sides running flat out.
    wait_drained();
    quiet_tail <= 1'b1;
    sender_gaps = 1'b0;
    configure($urandom_range(0, 255), $urandom_range(3, 10), $urandom_range(3, 6));
    stream_frame(50, 0);
    stream_frame(50, 0);

    wait_drained();
    run_done <= 1'b1;
    repeat (3) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/btc3_pkg.sv
hdl/btc3_in_if.sv
hdl/btc3_out_if.sv
hdl/binary_threshold_closing_3x3.sv
bench/binary_threshold_closing_3x3_checker.sv
bench/binary_threshold_closing_3x3_tb.sv
